@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files of the run-wise partition block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define RWOEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RWOEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define RWOEP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RWOEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/rwoep_pkg.sv @@
// Shared types and constants of the run-wise odd/even partition block.
package rwoep_pkg;

    localparam int DEFAULT_MAX_ITEMS = 64;
    localparam int DATA_W            = 32;

    // One list entry as it arrives.
    typedef struct packed {
        logic signed [DATA_W-1:0] in_group;
        logic signed [DATA_W-1:0] in_key;
        logic                     in_last;
    } t_in_item;

    // One list entry as it leaves.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_group;
        logic signed [DATA_W-1:0] out_key;
        logic                     out_last;
    } t_out_item;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_clr;
        logic adv;
        logic scan_rd;
        logic chk;
        logic swap_a;
        logic swap_b;
        logic emit_rd;
        logic emit_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_swap;
        logic last_pos;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/run_wise_odd_even_partition_top.sv @@
// Top level of the run-wise odd/even partition block.
//
// The block collects (group, key) items into a store of MAX_ITEMS entries, one item per
// cycle, until an item with in_last set; items beyond the store capacity are dropped, though
// a dropped last item still ends the list. It then scans the stored list in position order,
// each entry passing a read state and a check state, plus the swap states SWAP_A and SWAP_B
// when an odd key has to swap with the key at the write pointer: both swap reads and writes
// share the single read and write port of the key memory. Emission reads each entry from
// memory, then loads it into the output register, waiting while the output is stalled.
// Input is stalled from the last item until the final result has been placed in the output
// register; the next list can load while that result waits. No clearing pass is needed
// after reset.
`include "assert_macros.svh"

module run_wise_odd_even_partition_top
    import rwoep_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    rwoep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.in_last),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Stores and datapath.
    rwoep_dpath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // An emitted item never overwrites one still waiting at the output.
    `RWOEP_ASSERT_NOW(a_emit_into_free, i_clk, i_rst_n, cmd.emit_ld, sts.out_free)
    // The first half of a swap is always followed by the second half.
    `RWOEP_ASSERT_NEXT(a_swap_pair, i_clk, i_rst_n, cmd.swap_a, cmd.swap_b)
    // Once the final item of a list is emitted, input is open again.
    `RWOEP_ASSERT_NEXT(a_reopen_input, i_clk, i_rst_n, cmd.emit_ld && sts.last_pos, !o_in_stall)

endmodule

@@ rtl/rwoep_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rwoep_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rwoep_ctrl.sv @@
// Controller state machine: load, per-entry scan and swap, then emission.
module rwoep_ctrl
    import rwoep_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_last,
    input  t_sts   i_sts,
    output t_cmd   o_cmd,
    output logic   o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.rd_clr = 1'b1;
                    n_state      = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.need_swap) begin
                    n_state = ST_SWAP_A;
                end else if (i_sts.last_pos) begin
                    o_cmd.rd_clr = 1'b1;
                    n_state      = ST_EMIT_RD;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_SCAN_RD;
                end
            end
            ST_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = ST_SWAP_B;
            end
            ST_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                if (i_sts.last_pos) begin
                    o_cmd.rd_clr = 1'b1;
                    n_state      = ST_EMIT_RD;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_SCAN_RD;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                    if (i_sts.last_pos) begin
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state   = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

@@ rtl/rwoep_dpath.sv @@
// Datapath: entry stores, scan pointers, swap registers and the output register.
module rwoep_dpath
    import rwoep_pkg::*;
#(
    parameter  int MAX_ITEMS = DEFAULT_MAX_ITEMS,
    localparam int AW        = $clog2(MAX_ITEMS),
    localparam int CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_item,
    input  logic      i_out_stall,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_ITEMS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ITEMS - 1);

    logic [CW-1:0]     r_count;
    logic [AW-1:0]     r_last_idx;
    logic [AW-1:0]     r_rd;
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_swap_addr;
    logic [DATA_W-1:0] r_prev_grp;
    logic [DATA_W-1:0] r_key_rd;
    logic [DATA_W-1:0] r_key_wr;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              room;
    logic [DATA_W-1:0] grp_q;
    logic [DATA_W-1:0] key_q;
    logic              run_start;
    logic [AW-1:0]     wr_eff;
    logic              key_odd;
    logic              need_swap;
    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic [DATA_W-1:0] key_wdata;
    logic              key_re;
    logic [AW-1:0]     key_raddr;

    assign room = (r_count < MAX_CNT);

    // Run tracking: a new run starts at position zero or where the group changes.
    assign run_start = (r_rd == '0) || (grp_q != r_prev_grp);
    assign wr_eff    = run_start ? r_rd : r_wr;
    assign key_odd   = key_q[0];
    assign need_swap = key_odd && (wr_eff != r_rd);

    // Group store: written on load, read in position order.
    rwoep_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_item.in_group),
        .i_re    (i_cmd.scan_rd || i_cmd.emit_rd),
        .i_raddr (r_rd),
        .o_rdata (grp_q)
    );

    // Key store port selection: load, then the two halves of a swap.
    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_count[AW-1:0];
        key_wdata = i_in_item.in_key;
        if (i_cmd.load) begin
            key_we = room;
        end else if (i_cmd.swap_a) begin
            key_we    = 1'b1;
            key_waddr = r_swap_addr;
            key_wdata = r_key_rd;
        end else if (i_cmd.swap_b) begin
            key_we    = 1'b1;
            key_waddr = r_rd;
            key_wdata = r_key_wr;
        end
    end

    assign key_re    = i_cmd.scan_rd || i_cmd.emit_rd || (i_cmd.chk && need_swap);
    assign key_raddr = i_cmd.chk ? wr_eff : r_rd;

    rwoep_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_q)
    );

    // Control registers: fill count, scan position and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_in_item.in_last) begin
                    r_count <= '0;
                end else if (room) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.rd_clr) begin
                r_rd <= '0;
            end else if (i_cmd.adv) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_cmd.emit_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: list end, previous group, write pointer, swap values and the output item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_in_item.in_last) begin
            r_last_idx <= room ? r_count[AW-1:0] : LAST_ADDR;
        end
        if (i_cmd.chk) begin
            r_prev_grp  <= grp_q;
            r_key_rd    <= key_q;
            r_wr        <= wr_eff + AW'(key_odd);
            r_swap_addr <= wr_eff;
        end
        if (i_cmd.swap_a) begin
            r_key_wr <= key_q;
        end
        if (i_cmd.emit_ld) begin
            r_out_item.out_group <= grp_q;
            r_out_item.out_key   <= key_q;
            r_out_item.out_last  <= (r_rd == r_last_idx);
        end
    end

    assign o_sts.need_swap = need_swap;
    assign o_sts.last_pos  = (r_rd == r_last_idx);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
